### rtl/truss_bar_stress_recovery_defines.svh
// Assertion macros for the truss bar stress recovery checker.
`ifndef TRUSS_BAR_STRESS_RECOVERY_DEFINES_SVH
`define TRUSS_BAR_STRESS_RECOVERY_DEFINES_SVH

// Condition implies expression in the same cycle.
`define TBSR_ASSERT_NOW(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Condition implies expression in the next cycle.
`define TBSR_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### rtl/tbsr_pkg.sv
// Shared types and constants of the truss bar stress recovery block.
package tbsr_pkg;

    localparam int MUL_W      = 32;
    localparam int QUO_W      = 33;
    localparam int STRAIN_W   = 32;
    localparam int STRESS_W   = 64;
    localparam int FRAC_SHIFT = 30;
    localparam int AREA_FRAC  = 16;
    localparam int FSUM_W     = 96;
    localparam int FSH_W      = FSUM_W - AREA_FRAC;
    localparam int DCNT_W     = $clog2(QUO_W + 2);

    localparam logic [QUO_W-1:0] STRAIN_LIM_POS = 33'h0_7FFF_FFFF;
    localparam logic [QUO_W-1:0] STRAIN_LIM_NEG = 33'h0_8000_0000;
    localparam logic [FSH_W-1:0] FORCE_LIM_POS  = 80'h0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [FSH_W-1:0] FORCE_LIM_NEG  = 80'h0_8000_0000_0000_0000;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_ZERO_LEN = 2'd1;
    localparam status_t ST_SAT      = 2'd2;
    localparam status_t ST_NO_FIRST = 2'd3;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

    typedef enum logic [10:0] {
        S_IDLE       = 11'b000_0000_0001,
        S_MUL        = 11'b000_0000_0010,
        S_CHECK      = 11'b000_0000_0100,
        S_DIV        = 11'b000_0000_1000,
        S_SAT        = 11'b000_0001_0000,
        S_STRESS     = 11'b000_0010_0000,
        S_STRESS_CAP = 11'b000_0100_0000,
        S_FORCE_LO   = 11'b000_1000_0000,
        S_FORCE_HI   = 11'b001_0000_0000,
        S_FORCE_SUM  = 11'b010_0000_0000,
        S_OUT        = 11'b100_0000_0000
    } state_t;

endpackage

### rtl/truss_bar_stress_recovery.sv
// Truss bar axial stress recovery: top level with the sequencer and datapath.
// A first-end transaction is stored and gives no result. A second-end transaction
// with a stored first end forms the six products of the dot product and squared
// length on the shared 32x32 multiplier, then the bit-serial strain quotient, then
// the stress and force products on the same multiplier; a zero length skips the
// quotient and later products. The input is not ready until the result is placed
// in the output register, which then waits for the consumer on its own.
module truss_bar_stress_recovery
    import tbsr_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 node_end,
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_y,
    input  logic signed [31:0]   pos_z,
    input  logic signed [31:0]   disp_x,
    input  logic signed [31:0]   disp_y,
    input  logic signed [31:0]   disp_z,
    input  logic [31:0]          section_area,
    input  logic [31:0]          elastic_modulus,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   axial_strain,
    output logic signed [63:0]   axial_stress,
    output logic signed [63:0]   axial_force,
    output logic [1:0]           status
);

    localparam int VW    = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam int PR_W  = 2 * VW;
    localparam int LEN_W = 2 * VW + 2;
    localparam int DOT_W = 2 * VW + 3;
    localparam int NUM_W = LEN_W + FRAC_SHIFT;

    state_t state_reg;
    state_t state_next;
    logic   held_reg;
    logic   held_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic [2:0] mcnt_reg;
    logic [2:0] mcnt_next;
    logic   pend_reg;
    logic   pend_next;

    logic [VW-1:0] held_pos_reg [3];
    logic [VW-1:0] held_disp_reg [3];
    logic [VW-1:0] mp_reg [3];
    logic [VW-1:0] mu_reg [3];
    logic          np_reg [3];
    logic          nu_reg [3];
    logic [31:0]   area_reg;
    logic [31:0]   modulus_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic [LEN_W-1:0]        len2_reg;
    logic          acc_dot_reg;
    logic          acc_neg_reg;
    logic          dot_neg_reg;
    logic          sat_reg;
    status_t       status_reg;
    logic [STRAIN_W-1:0] strain_mag_reg;
    logic [STRESS_W-1:0] stress_reg;
    logic [2*MUL_W-1:0]  plo_reg;
    logic [STRESS_W-1:0] force_mag_reg;

    logic signed [31:0]   out_strain_reg;
    logic signed [63:0]   out_stress_reg;
    logic signed [63:0]   out_force_reg;
    status_t              out_status_reg;

    logic [31:0]   in_pos [3];
    logic [31:0]   in_disp [3];
    logic [VW:0]   dp [3];
    logic [VW:0]   du [3];
    logic [VW:0]   dp_neg [3];
    logic [VW:0]   du_neg [3];
    logic [VW-1:0] mp_in [3];
    logic [VW-1:0] mu_in [3];

    logic [1:0]          sel;
    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [2*MUL_W-1:0]  product;
    logic [DOT_W-1:0]    dot_mag;
    logic [NUM_W-1:0]    div_num;
    logic [QUO_W-1:0]    quo;
    div_stat_t           div_stat;
    logic [QUO_W-1:0]    strain_lim;
    logic [FSUM_W-1:0]   fsum;
    logic [FSH_W-1:0]    fshift;
    logic [FSH_W-1:0]    force_lim;
    logic                fsat;
    logic                accept;
    logic                load_out;
    logic                zero_out;

    assign in_pos  = '{pos_x, pos_y, pos_z};
    assign in_disp = '{disp_x, disp_y, disp_z};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dp[i] = {in_pos[i][VW-1], in_pos[i][VW-1:0]}
                  - {held_pos_reg[i][VW-1], held_pos_reg[i]};
            du[i] = {in_disp[i][VW-1], in_disp[i][VW-1:0]}
                  - {held_disp_reg[i][VW-1], held_disp_reg[i]};
            dp_neg[i] = -dp[i];
            du_neg[i] = -du[i];
            mp_in[i]  = dp[i][VW] ? dp_neg[i][VW-1:0] : dp[i][VW-1:0];
            mu_in[i]  = du[i][VW] ? du_neg[i][VW-1:0] : du[i][VW-1:0];
        end
    end

    assign accept   = in_valid && in_ready;
    assign in_ready = state_reg == S_IDLE;
    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign zero_out = (status_reg == ST_ZERO_LEN) || (status_reg == ST_NO_FIRST);

    always_comb
    begin
        sel   = (mcnt_reg < 3'd6) ? mcnt_reg[2:1] : 2'd0;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL:
            begin
                mul_a = MUL_W'(mp_reg[sel]);
                mul_b = mcnt_reg[0] ? MUL_W'(mu_reg[sel]) : MUL_W'(mp_reg[sel]);
            end
            S_STRESS:
            begin
                mul_a = strain_mag_reg;
                mul_b = modulus_reg;
            end
            S_FORCE_LO:
            begin
                mul_a = stress_reg[31:0];
                mul_b = area_reg;
            end
            S_FORCE_HI:
            begin
                mul_a = stress_reg[63:32];
                mul_b = area_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    tbsr_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    always_comb
    begin
        dot_mag = dot_reg[DOT_W-1] ? -dot_reg : dot_reg;
        div_num = {dot_mag[LEN_W-1:0], {FRAC_SHIFT{1'b0}}};
    end

    tbsr_div #(
        .NUM_W (NUM_W),
        .DEN_W (LEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_CHECK),
        .num   (div_num),
        .den   (len2_reg),
        .quo   (quo),
        .stat  (div_stat)
    );

    always_comb
    begin
        strain_lim = dot_neg_reg ? STRAIN_LIM_NEG : STRAIN_LIM_POS;
        force_lim  = dot_neg_reg ? FORCE_LIM_NEG : FORCE_LIM_POS;
        fsum       = {product, 32'h0} + FSUM_W'(plo_reg);
        fshift     = fsum[FSUM_W-1:AREA_FRAC];
        fsat       = fshift > force_lim;
    end

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        mcnt_next      = mcnt_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                mcnt_next = '0;
                if (accept)
                begin
                    held_next = !node_end;
                    if (node_end)
                    begin
                        state_next = held_reg ? S_MUL : S_OUT;
                    end
                end
            end
            S_MUL:
            begin
                mcnt_next = mcnt_reg + 3'd1;
                pend_next = mcnt_reg < 3'd6;
                if (mcnt_reg == 3'd6)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = (len2_reg == '0) ? S_OUT : S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:        state_next = S_STRESS;
            S_STRESS:     state_next = S_STRESS_CAP;
            S_STRESS_CAP: state_next = S_FORCE_LO;
            S_FORCE_LO:   state_next = S_FORCE_HI;
            S_FORCE_HI:   state_next = S_FORCE_SUM;
            S_FORCE_SUM:  state_next = S_OUT;
            S_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            mcnt_reg      <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            mcnt_reg      <= mcnt_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                held_pos_reg[i]  <= '0;
                held_disp_reg[i] <= '0;
            end
        end
        else if (accept && !node_end)
        begin
            for (int i = 0; i < 3; i++)
            begin
                held_pos_reg[i]  <= in_pos[i][VW-1:0];
                held_disp_reg[i] <= in_disp[i][VW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept && node_end)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mp_reg[i] <= mp_in[i];
                        mu_reg[i] <= mu_in[i];
                        np_reg[i] <= dp[i][VW];
                        nu_reg[i] <= du[i][VW];
                    end
                    area_reg    <= section_area;
                    modulus_reg <= elastic_modulus;
                    dot_reg     <= '0;
                    len2_reg    <= '0;
                    sat_reg     <= 1'b0;
                    status_reg  <= held_reg ? ST_OK : ST_NO_FIRST;
                end
            end
            S_MUL:
            begin
                acc_dot_reg <= mcnt_reg[0];
                acc_neg_reg <= np_reg[sel] ^ nu_reg[sel];
                if (pend_reg)
                begin
                    if (!acc_dot_reg)
                    begin
                        len2_reg <= len2_reg + LEN_W'(product[PR_W-1:0]);
                    end
                    else if (acc_neg_reg)
                    begin
                        dot_reg <= dot_reg - $signed(DOT_W'(product[PR_W-1:0]));
                    end
                    else
                    begin
                        dot_reg <= dot_reg + $signed(DOT_W'(product[PR_W-1:0]));
                    end
                end
            end
            S_CHECK:
            begin
                dot_neg_reg <= dot_reg[DOT_W-1];
                if (len2_reg == '0)
                begin
                    status_reg <= ST_ZERO_LEN;
                end
            end
            S_SAT:
            begin
                if (div_stat.ovf || (quo > strain_lim))
                begin
                    strain_mag_reg <= strain_lim[STRAIN_W-1:0];
                    sat_reg        <= 1'b1;
                end
                else
                begin
                    strain_mag_reg <= quo[STRAIN_W-1:0];
                end
            end
            S_STRESS_CAP:
            begin
                stress_reg <= product;
            end
            S_FORCE_HI:
            begin
                plo_reg <= product;
            end
            S_FORCE_SUM:
            begin
                force_mag_reg <= fsat ? force_lim[STRESS_W-1:0] : fshift[STRESS_W-1:0];
                status_reg    <= (sat_reg || fsat) ? ST_SAT : ST_OK;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    out_status_reg <= status_reg;
                    if (zero_out)
                    begin
                        out_strain_reg <= '0;
                        out_stress_reg <= '0;
                        out_force_reg  <= '0;
                    end
                    else if (dot_neg_reg)
                    begin
                        out_strain_reg <= -$signed(strain_mag_reg);
                        out_stress_reg <= -$signed(stress_reg);
                        out_force_reg  <= -$signed(force_mag_reg);
                    end
                    else
                    begin
                        out_strain_reg <= $signed(strain_mag_reg);
                        out_stress_reg <= $signed(stress_reg);
                        out_force_reg  <= $signed(force_mag_reg);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign axial_strain = out_strain_reg;
    assign axial_stress = out_stress_reg;
    assign axial_force  = out_force_reg;
    assign status       = out_status_reg;

endmodule

### rtl/tbsr_mul.sv
// Shared unsigned multiplier with a registered product.
module tbsr_mul
    import tbsr_pkg::*;
(
    input  logic                 clk,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic [2*MUL_W-1:0]   product
);

    logic [2*MUL_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= a * b;
    end

    assign product = product_reg;

endmodule

### rtl/tbsr_div.sv
// Restoring divider that produces a bounded quotient one bit per cycle.
module tbsr_div
    import tbsr_pkg::*;
#(
    parameter int NUM_W = 96,
    parameter int DEN_W = 66
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic [QUO_W-1:0]  quo,
    output div_stat_t         stat
);

    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [QUO_W-1:0]  low_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              ovf_reg;
    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    trial;
    logic              ge;

    always_comb
    begin
        shifted  = {rem_reg, low_reg[QUO_W-1]};
        trial    = shifted - {1'b0, den_reg};
        ge       = shifted >= {1'b0, den_reg};
        rem_next = ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DCNT_W'(QUO_W + 1);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DEN_W'(num[NUM_W-1:QUO_W]);
            low_reg <= num[QUO_W-1:0];
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (cnt_reg == DCNT_W'(QUO_W + 1))
        begin
            ovf_reg <= rem_reg >= den_reg;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign quo       = quo_reg;
    assign stat.done = cnt_reg == DCNT_W'(1);
    assign stat.ovf  = ovf_reg;

endmodule

### rtl/tbsr_checker.sv
// Port-level checker for the truss bar stress recovery block, with its bind.
`include "truss_bar_stress_recovery_defines.svh"

module tbsr_checker
    import tbsr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic signed [31:0]  axial_strain,
    input logic signed [63:0]  axial_stress,
    input logic signed [63:0]  axial_force,
    input logic [1:0]          status
);

    // A stalled result transaction keeps its payload.
    `TBSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(axial_strain) && $stable(axial_stress) && $stable(axial_force) && $stable(status), "result changed while stalled")

    // Degenerate bars and missing first ends report all-zero values.
    `TBSR_ASSERT_NOW(a_zero_fields, out_valid && (status == ST_ZERO_LEN || status == ST_NO_FIRST), axial_strain == 0 && axial_stress == 0 && axial_force == 0, "nonzero values with error status")

    // A non-negative strain never gives a negative stress or force.
    `TBSR_ASSERT_NOW(a_sign_match, out_valid && !axial_strain[31], !axial_stress[63] && !axial_force[63], "stress or force sign disagrees with strain")

endmodule

bind truss_bar_stress_recovery tbsr_checker u_tbsr_checker (.*);
